// ===== hw/rtl/rgbled_pkg.sv =====
package rgbled_pkg;

    // Event kinds carried in the input tuser bit
    typedef enum logic {
        t_MODE_UPDATE   = 1'b0,
        t_MODE_FEEDBACK = 1'b1
    } t_mode;

    // Target position classes
    typedef enum logic [1:0] {
        SIGN_ZERO      = 2'd0,
        SIGN_POSITIVE  = 2'd1,
        SIGN_NEGATIVE  = 2'd2,
        SIGN_UNORDERED = 2'd3
    } t_sign;

    // LED color codes: bit0 blue, bit1 green, bit2 red
    localparam logic [2:0] COLOR_OFF   = 3'b000;
    localparam logic [2:0] COLOR_BLUE  = 3'b001;
    localparam logic [2:0] COLOR_GREEN = 3'b010;
    localparam logic [2:0] COLOR_CYAN  = 3'b011;
    localparam logic [2:0] COLOR_RED   = 3'b100;

    localparam int PATTERN_W = 6;
    localparam logic [7:0] DIMMER_RESET = 8'd10;

    // Register byte addresses
    localparam logic ADDR_DIMMER_PERIOD = 1'b0;

    // One input item as it moves down the pipeline
    typedef struct packed {
        t_mode       mode;
        logic [31:0] now_us;
        t_sign       target_sign;
        logic        zone_warn;
        logic [2:0]  color;
        logic [31:0] hold_us;
    } t_item;

endpackage

// ===== hw/rtl/rgbled_blink.sv =====
module rgbled_blink
    import rgbled_pkg::*;
#(
    parameter int BLINK_HALF_PERIOD_US = 250000
) (
    input  logic        i_clk,
    input  logic        i_adv,
    input  logic [31:0] i_now_s1,
    input  logic [31:0] i_now_s2,
    output logic        o_odd
);

    // Reciprocal of the half period, scaled by 2^32
    localparam logic [64:0] RECIP_WIDE = (65'd1 << 32) / 65'(BLINK_HALF_PERIOD_US);
    localparam logic [32:0] RECIP      = RECIP_WIDE[32:0];
    localparam logic [33:0] HALF_P     = 34'(BLINK_HALF_PERIOD_US);

    logic [64:0] w_prod;
    logic [32:0] r_qest;
    logic [33:0] w_qb;
    logic [33:0] w_rem;

    // Estimate the quotient; it is low by at most one
    assign w_prod = 65'(i_now_s1) * 65'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_qest <= w_prod[64:32];
        end
    end

    // Correct the estimate by one where the remainder reaches the divisor
    assign w_qb  = 34'(r_qest) * HALF_P;
    assign w_rem = {2'b00, i_now_s2} - w_qb;
    assign o_odd = r_qest[0] ^ (w_rem >= HALF_P);

endmodule

// ===== hw/rtl/rgbled_disp.sv =====
module rgbled_disp
    import rgbled_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_valid,
    input  t_item                i_item,
    input  logic                 i_blink_odd,
    input  logic [7:0]           i_dimmer_period,
    output logic                 o_busy,
    output logic                 o_valid,
    output logic [PATTERN_W-1:0] o_pattern
);

    logic                 r_fb_on;
    logic [2:0]           r_fb_rgb;
    logic [31:0]          r_fb_deadline;
    logic [PATTERN_W-1:0] r_last;
    logic [7:0]           r_dim_count;
    logic [7:0]           r_dim_rem;
    logic [7:0]           r_per;
    logic                 r_sync;
    logic [2:0]           r_sync_bit;
    logic [7:0]           r_sync_acc;
    logic                 r_valid;
    logic [PATTERN_W-1:0] r_pattern;

    logic                 n_fb_on;
    logic [2:0]           n_fb_rgb;
    logic [31:0]          n_fb_deadline;
    logic [PATTERN_W-1:0] n_last;
    logic [7:0]           n_dim_count;
    logic [7:0]           n_dim_rem;
    logic [7:0]           n_per;
    logic                 n_sync;
    logic [2:0]           n_sync_bit;
    logic [7:0]           n_sync_acc;
    logic                 n_valid;
    logic [PATTERN_W-1:0] n_pattern;

    logic [31:0]          w_diff;
    logic                 w_live;
    logic [PATTERN_W-1:0] w_choice;
    logic [7:0]           w_count;
    logic [7:0]           w_per;
    logic                 w_hit;
    logic                 w_show;
    logic [8:0]           w_sync_shift;
    logic [8:0]           w_sync_acc;

    // Check the feedback deadline as a signed difference
    assign w_diff = r_fb_deadline - i_item.now_us;
    assign w_live = r_fb_on && ((r_fb_deadline == 32'd0) || ((w_diff != 32'd0) && !w_diff[31]));

    // Pick the status colors
    always_comb begin
        if (i_item.zone_warn) begin
            w_choice = i_blink_odd ? {COLOR_RED, COLOR_OFF} : {COLOR_OFF, COLOR_RED};
        end else begin
            unique case (i_item.target_sign)
                SIGN_ZERO:     w_choice = {COLOR_CYAN, COLOR_CYAN};
                SIGN_POSITIVE: w_choice = {COLOR_GREEN, COLOR_OFF};
                SIGN_NEGATIVE: w_choice = {COLOR_OFF, COLOR_BLUE};
                default:       w_choice = {COLOR_OFF, COLOR_RED};
            endcase
        end
    end

    // Dim an unchanged pattern; a zero period acts as one. The count is tracked
    // modulo the period, so a multiple of the period is a single compare.
    assign w_per   = (i_dimmer_period == 8'd0) ? 8'd1 : i_dimmer_period;
    assign w_count = r_dim_count + 8'd1;
    assign w_hit   = (w_count == 8'd0) || ((r_dim_rem + 8'd1) == r_per);
    assign w_show  = (w_choice != r_last) || w_hit;

    // One restoring step of the count remainder, used after a period change
    assign w_sync_shift = {r_sync_acc, r_dim_count[r_sync_bit]};
    assign w_sync_acc   = (w_sync_shift >= {1'b0, r_per}) ? (w_sync_shift - {1'b0, r_per})
                                                           : w_sync_shift;

    assign o_busy = r_sync || (w_per != r_per);

    // Update state and the result for the item in the last stage
    always_comb begin
        n_fb_on       = r_fb_on;
        n_fb_rgb      = r_fb_rgb;
        n_fb_deadline = r_fb_deadline;
        n_last        = r_last;
        n_dim_count   = r_dim_count;
        n_dim_rem     = r_dim_rem;
        n_per         = r_per;
        n_sync        = r_sync;
        n_sync_bit    = r_sync_bit;
        n_sync_acc    = r_sync_acc;
        n_valid       = r_valid;
        n_pattern     = r_pattern;
        if (i_adv) begin
            n_valid = 1'b0;
            if (i_valid) begin
                if (i_item.mode == t_MODE_FEEDBACK) begin
                    n_fb_on       = 1'b1;
                    n_fb_rgb      = i_item.color;
                    n_fb_deadline = (i_item.hold_us == 32'd0) ? 32'd0
                                  : i_item.now_us + i_item.hold_us;
                end else if (w_live) begin
                    n_valid   = 1'b1;
                    n_pattern = {r_fb_rgb, r_fb_rgb};
                    n_last    = {r_fb_rgb, r_fb_rgb};
                end else begin
                    n_fb_on       = 1'b0;
                    n_fb_deadline = 32'd0;
                    n_valid       = 1'b1;
                    n_pattern     = w_show ? w_choice : '0;
                    n_dim_count   = w_show ? 8'd0 : w_count;
                    n_dim_rem     = w_show ? 8'd0 : (r_dim_rem + 8'd1);
                    n_last        = w_choice;
                end
            end
        end
        // Rebuild the count remainder one bit per cycle after a period change
        if (r_sync) begin
            n_sync_acc = w_sync_acc[7:0];
            if (r_sync_bit == 3'd0) begin
                n_sync    = 1'b0;
                n_dim_rem = w_sync_acc[7:0];
            end else begin
                n_sync_bit = r_sync_bit - 3'd1;
            end
        end else if (w_per != r_per) begin
            n_sync     = 1'b1;
            n_per      = w_per;
            n_sync_bit = 3'd7;
            n_sync_acc = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb_on       <= 1'b0;
            r_fb_rgb      <= COLOR_OFF;
            r_fb_deadline <= 32'd0;
            r_last        <= '0;
            r_dim_count   <= 8'd0;
            r_dim_rem     <= 8'd0;
            r_per         <= DIMMER_RESET;
            r_sync        <= 1'b0;
            r_sync_bit    <= 3'd0;
            r_sync_acc    <= 8'd0;
            r_valid       <= 1'b0;
        end else begin
            r_fb_on       <= n_fb_on;
            r_fb_rgb      <= n_fb_rgb;
            r_fb_deadline <= n_fb_deadline;
            r_last        <= n_last;
            r_dim_count   <= n_dim_count;
            r_dim_rem     <= n_dim_rem;
            r_per         <= n_per;
            r_sync        <= n_sync;
            r_sync_bit    <= n_sync_bit;
            r_sync_acc    <= n_sync_acc;
            r_valid       <= n_valid;
        end
    end

    // Hold the result payload
    always_ff @(posedge i_clk) begin
        r_pattern <= n_pattern;
    end

    assign o_valid   = r_valid;
    assign o_pattern = r_pattern;

endmodule

// ===== hw/rtl/rgb_status_led_controller_core.sv =====
// Channel    | Direction | Beat contents
// -----------+-----------+---------------------------------------------------------
// s stream   | in        | tdata: now_us, target_sign, zone_warn, color,
//            |           |        hold_us; tuser: mode
// m stream   | out       | tdata: led_pattern
// APB        | in/out    | dimmer_period at byte address 0
//
// Three register stages: input, blink quotient estimate, result. A beat reaches the
// result register via the estimate stage; a beat is accepted each cycle unless stalled or busy.
// The quotient estimate multiplier sets the middle stage; state updates in the last.
// Reset (synchronous, active low) clears control state and sets dimmer_period to 10.
// A stall on the output holds every stage; feedback beats give no result beat.
// A new dimmer_period holds the input while the dim remainder rebuilds.
module rgb_status_led_controller_core
    import rgbled_pkg::*;
#(
    parameter int BLINK_HALF_PERIOD_US = 250000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [31:0] now_us, [33:32] target_sign, [34] zone_warn, [37:35] color,
    // [69:38] hold_us, [71:70] zero
    input  logic [71:0] i_s_tdata,
    // [0] mode
    input  logic        i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [5:0] led_pattern, [7:6] zero
    output logic [7:0]  o_m_tdata,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    logic                 w_adv;
    logic                 w_busy;
    t_item                w_in_item;
    t_item                r_item1;
    t_item                r_item2;
    logic                 r_v1;
    logic                 r_v2;
    logic                 w_odd;
    logic                 w_out_valid;
    logic [PATTERN_W-1:0] w_pattern;
    logic [7:0]           r_dimmer;

    // Unpack the input beat
    assign w_in_item.mode        = t_mode'(i_s_tuser);
    assign w_in_item.now_us      = i_s_tdata[31:0];
    assign w_in_item.target_sign = t_sign'(i_s_tdata[33:32]);
    assign w_in_item.zone_warn   = i_s_tdata[34];
    assign w_in_item.color       = i_s_tdata[37:35];
    assign w_in_item.hold_us     = i_s_tdata[69:38];

    // Advance the whole pipeline while the result register can take a beat;
    // hold off new beats while the dim remainder rebuilds
    assign w_adv      = !w_out_valid || i_m_tready;
    assign o_s_tready = w_adv && !w_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_s_tvalid && !w_busy;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_item1 <= w_in_item;
            r_item2 <= r_item1;
        end
    end

    rgbled_blink #(
        .BLINK_HALF_PERIOD_US (BLINK_HALF_PERIOD_US)
    ) u_blink (
        .i_clk    (i_clk),
        .i_adv    (w_adv),
        .i_now_s1 (r_item1.now_us),
        .i_now_s2 (r_item2.now_us),
        .o_odd    (w_odd)
    );

    rgbled_disp u_disp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (w_adv),
        .i_valid         (r_v2),
        .i_item          (r_item2),
        .i_blink_odd     (w_odd),
        .i_dimmer_period (r_dimmer),
        .o_busy          (w_busy),
        .o_valid         (w_out_valid),
        .o_pattern       (w_pattern)
    );

    assign o_m_tvalid = w_out_valid;
    assign o_m_tdata  = {2'b00, w_pattern};

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dimmer <= DIMMER_RESET;
        end else if (i_psel && i_penable && i_pwrite && (i_paddr == ADDR_DIMMER_PERIOD)) begin
            r_dimmer <= i_pwdata[7:0];
        end
    end

    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr == ADDR_DIMMER_PERIOD) ? {24'd0, r_dimmer} : 32'd0;

endmodule
